### hw/rtl/apu_pkg.sv
// Shared widths, register indexes and the sideband type for the alpha premultiply unit.
`timescale 1ns / 1ps
`default_nettype none

package apu_pkg;

    // Channel and numerator widths
    localparam int CHAN_W    = 8;
    localparam int NUM_W     = 2 * CHAN_W;
    localparam int CFG_IDX_W = 1;

    // Full-scale channel value
    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    // One restoring step per quotient bit; quotient never exceeds CHAN_MAX
    localparam int DIV_STEPS = CHAN_W;

    // Operand register, divider steps, output register
    localparam int PIPE_DEPTH = DIV_STEPS + 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDITIVE  = 1'd1;

    // Per-request data that bypasses the color lanes
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic              zero_alpha;
        logic              last;
    } t_side;

endpackage

`default_nettype wire

### hw/rtl/alpha_premultiply_unit_top.sv
// Top level of the alpha premultiply / unpremultiply unit.
// A request's result passes through the operand register, the divider steps and
// the output register, and shows on the outputs for one cycle with o_strobe high.
// Throughput: one pixel per cycle; each color lane runs an 8-step pipelined
// divider, one quotient bit per stage. busy stays low.
// Reset: synchronous, active low; clears the pipeline valids and both
// configuration registers (premultiply, alpha kept).
`timescale 1ns / 1ps
`default_nettype none

module alpha_premultiply_unit_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [apu_pkg::CHAN_W-1:0]    i_red_in,
    input  wire logic [apu_pkg::CHAN_W-1:0]    i_green_in,
    input  wire logic [apu_pkg::CHAN_W-1:0]    i_blue_in,
    input  wire logic [apu_pkg::CHAN_W-1:0]    i_alpha_in,
    input  wire logic                          i_last_pixel,
    input  wire logic                          i_cfg_we,
    input  wire logic [apu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic                          i_cfg_wdata,
    output logic                               o_strobe,
    output logic      [apu_pkg::CHAN_W-1:0]    o_red_out,
    output logic      [apu_pkg::CHAN_W-1:0]    o_green_out,
    output logic      [apu_pkg::CHAN_W-1:0]    o_blue_out,
    output logic      [apu_pkg::CHAN_W-1:0]    o_alpha_out,
    output logic                               o_last_out
);

    // Fully pipelined: never refuses a request
    assign busy = 1'b0;

    logic n_accept;
    assign n_accept = start && !busy;

    // Configuration registers
    logic r_direction;
    logic r_additive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_additive  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                apu_pkg::REG_DIRECTION: r_direction <= i_cfg_wdata;
                apu_pkg::REG_ADDITIVE:  r_additive  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Color lanes
    logic [apu_pkg::CHAN_W-1:0] w_red;
    logic [apu_pkg::CHAN_W-1:0] w_green;
    logic [apu_pkg::CHAN_W-1:0] w_blue;

    apu_lane u_lane_red (
        .i_clk       (i_clk),
        .i_chan      (i_red_in),
        .i_alpha     (i_alpha_in),
        .i_direction (r_direction),
        .o_chan      (w_red)
    );

    apu_lane u_lane_green (
        .i_clk       (i_clk),
        .i_chan      (i_green_in),
        .i_alpha     (i_alpha_in),
        .i_direction (r_direction),
        .o_chan      (w_green)
    );

    apu_lane u_lane_blue (
        .i_clk       (i_clk),
        .i_chan      (i_blue_in),
        .i_alpha     (i_alpha_in),
        .i_direction (r_direction),
        .o_chan      (w_blue)
    );

    // Sideband for the merge stage
    apu_pkg::t_side w_side;

    always_comb begin
        w_side.alpha      = i_alpha_in;
        w_side.zero_alpha = r_additive;
        w_side.last       = i_last_pixel;
    end

    apu_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (n_accept),
        .i_side   (w_side),
        .i_red    (w_red),
        .i_green  (w_green),
        .i_blue   (w_blue),
        .o_strobe (o_strobe),
        .o_red    (o_red_out),
        .o_green  (o_green_out),
        .o_blue   (o_blue_out),
        .o_alpha  (o_alpha_out),
        .o_last   (o_last_out)
    );

endmodule

`default_nettype wire

### hw/rtl/apu_lane.sv
// One color lane: operand setup followed by a pipelined restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module apu_lane (
    input  wire logic                       i_clk,
    input  wire logic [apu_pkg::CHAN_W-1:0] i_chan,
    input  wire logic [apu_pkg::CHAN_W-1:0] i_alpha,
    input  wire logic                       i_direction,
    output logic      [apu_pkg::CHAN_W-1:0] o_chan
);

    localparam int CW = apu_pkg::CHAN_W;
    localparam int NW = apu_pkg::NUM_W;
    localparam int DS = apu_pkg::DIV_STEPS;

    // Operand setup: premultiply divides chan*alpha by 255,
    // unpremultiply divides chan*255 by alpha
    logic [NW-1:0] n_num;
    logic [CW-1:0] n_div;
    logic          n_byp;
    logic          n_sat;

    always_comb begin
        if (i_direction) begin
            n_num = {i_chan, {CW{1'b0}}} - NW'(i_chan);
            n_div = i_alpha;
        end else begin
            n_num = NW'(i_chan) * NW'(i_alpha);
            n_div = apu_pkg::CHAN_MAX;
        end
        // zero alpha on divide leaves the color as is
        n_byp = i_direction && (i_alpha == '0);
        // quotient would exceed 255
        n_sat = i_direction && (n_num >= {i_alpha, {CW{1'b0}}});
    end

    // Pipeline registers, index 0 is the operand stage
    logic [NW-1:0] r_rem  [0:DS];
    logic [CW-1:0] r_quo  [0:DS];
    logic [CW-1:0] r_div  [0:DS];
    logic [CW-1:0] r_chan [0:DS];
    logic          r_byp  [0:DS];
    logic          r_sat  [0:DS];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= n_num;
        r_quo[0]  <= '0;
        r_div[0]  <= n_div;
        r_chan[0] <= i_chan;
        r_byp[0]  <= n_byp;
        r_sat[0]  <= n_sat;
    end

    // Divider steps, most significant quotient bit first
    for (genvar k = 0; k < DS; k++) begin : g_step
        localparam int SH = DS - 1 - k;

        logic [NW:0]   n_dsh;
        logic [NW:0]   n_trial;
        logic [NW-1:0] n_rem;
        logic [CW-1:0] n_quo;

        always_comb begin
            n_dsh   = (NW + 1)'(r_div[k]) << SH;
            n_trial = {1'b0, r_rem[k]} - n_dsh;
            if (!n_trial[NW]) begin
                n_rem = n_trial[NW-1:0];
                n_quo = r_quo[k] | (CW'(1) << SH);
            end else begin
                n_rem = r_rem[k];
                n_quo = r_quo[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= n_rem;
            r_quo[k+1]  <= n_quo;
            r_div[k+1]  <= r_div[k];
            r_chan[k+1] <= r_chan[k];
            r_byp[k+1]  <= r_byp[k];
            r_sat[k+1]  <= r_sat[k];
        end
    end

    // Special cases override the quotient
    always_comb begin
        priority if (r_byp[DS]) begin
            o_chan = r_chan[DS];
        end else if (r_sat[DS]) begin
            o_chan = apu_pkg::CHAN_MAX;
        end else begin
            o_chan = r_quo[DS];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/apu_merge.sv
// Merge stage: aligns alpha and last mark with the lanes and registers the result.
`timescale 1ns / 1ps
`default_nettype none

module apu_merge (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire apu_pkg::t_side             i_side,
    input  wire logic [apu_pkg::CHAN_W-1:0] i_red,
    input  wire logic [apu_pkg::CHAN_W-1:0] i_green,
    input  wire logic [apu_pkg::CHAN_W-1:0] i_blue,
    output logic                            o_strobe,
    output logic      [apu_pkg::CHAN_W-1:0] o_red,
    output logic      [apu_pkg::CHAN_W-1:0] o_green,
    output logic      [apu_pkg::CHAN_W-1:0] o_blue,
    output logic      [apu_pkg::CHAN_W-1:0] o_alpha,
    output logic                            o_last
);

    localparam int PD = apu_pkg::PIPE_DEPTH;
    localparam int SD = PD - 1;

    // Request valid shift line
    logic [PD-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PD-2:0], i_accept};
        end
    end

    // Sideband delay matching the lane depth
    apu_pkg::t_side r_side [0:SD-1];

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        for (int j = 1; j < SD; j++) begin
            r_side[j] <= r_side[j-1];
        end
    end

    // Output register
    logic [apu_pkg::CHAN_W-1:0] r_red;
    logic [apu_pkg::CHAN_W-1:0] r_green;
    logic [apu_pkg::CHAN_W-1:0] r_blue;
    logic [apu_pkg::CHAN_W-1:0] r_alpha;
    logic                       r_last;

    always_ff @(posedge i_clk) begin
        r_red   <= i_red;
        r_green <= i_green;
        r_blue  <= i_blue;
        r_alpha <= r_side[SD-1].zero_alpha ? '0 : r_side[SD-1].alpha;
        r_last  <= r_side[SD-1].last;
    end

    assign o_strobe = r_vld[PD-1];
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;
    assign o_alpha  = r_alpha;
    assign o_last   = r_last;

endmodule

`default_nettype wire

### hw/rtl/apu_checker.sv
// Port-level checker for the alpha premultiply unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module apu_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       i_last_pixel,
    input wire logic [apu_pkg::CHAN_W-1:0] i_alpha_in,
    input wire logic                       o_strobe,
    input wire logic                       o_last_out,
    input wire logic [apu_pkg::CHAN_W-1:0] o_alpha_out
);

    // Every accepted request yields its result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(apu_pkg::PIPE_DEPTH) o_strobe)
        else $error("accepted request produced no result");

    // No result without a matching request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, apu_pkg::PIPE_DEPTH))
        else $error("result strobe without a request");

    // Last mark travels with its pixel
    a_last_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last_out == $past(i_last_pixel, apu_pkg::PIPE_DEPTH)))
        else $error("last mark out of step with its pixel");

    // Alpha is either passed through or zeroed
    a_alpha_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_alpha_out == $past(i_alpha_in, apu_pkg::PIPE_DEPTH))
                      || (o_alpha_out == '0)))
        else $error("alpha out does not match the request");

endmodule

bind alpha_premultiply_unit_top apu_checker u_apu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_last_pixel (i_last_pixel),
    .i_alpha_in   (i_alpha_in),
    .o_strobe     (o_strobe),
    .o_last_out   (o_last_out),
    .o_alpha_out  (o_alpha_out)
);

`default_nettype wire
